/* rtl/d64r_pkg.sv */
// Package for the sector chain file reader: widths, op codes, image geometry
// and the track-to-sector-index table. No dependencies.
`default_nettype none

package d64r_pkg;

  localparam int IMAGE_SECTORS   = 683;
  localparam int SECTOR_BYTES    = 256;
  localparam int IMAGE_BYTES     = IMAGE_SECTORS * SECTOR_BYTES;
  localparam int NUM_TRACKS      = 35;
  localparam int DATA_PER_SECTOR = 254;

  localparam int ADDR_W = 18;
  localparam int IDX_W  = 10;   // track base plus sector, up to 921
  localparam int POS_W  = 9;

  typedef logic [1:0]        op_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [7:0]        byte_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_OPEN  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam byte_t LINK_SECTOR_OFS = 8'h01;

  // result of one location lookup
  typedef struct packed {
    logic ok;
    idx_t idx;
  } loc_t;

  // first sector index of a track (1..35); speed zones of 21, 19, 18, 17
  function automatic idx_t track_base(input logic [5:0] t);
    idx_t tt;
    idx_t res;
    begin
      tt = {4'd0, t};
      if (t >= 6'd31) begin
        res = idx_t'(598) + (tt - idx_t'(31)) * idx_t'(17);
      end else if (t >= 6'd25) begin
        res = idx_t'(490) + (tt - idx_t'(25)) * idx_t'(18);
      end else if (t >= 6'd18) begin
        res = idx_t'(357) + (tt - idx_t'(18)) * idx_t'(19);
      end else begin
        res = (tt - idx_t'(1)) * idx_t'(21);
      end
      return res;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/d64r_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on d64r_pkg.
`default_nettype none

interface d64r_req_if;
  logic               valid;
  logic               ready;
  d64r_pkg::op_t      op;
  d64r_pkg::addr_t    image_address;
  d64r_pkg::byte_t    image_byte;
  d64r_pkg::byte_t    start_track;
  d64r_pkg::byte_t    start_sector;

  modport source(output valid, op, image_address, image_byte, start_track, start_sector,
                 input ready);
  modport sink(input valid, op, image_address, image_byte, start_track, start_sector,
               output ready);
endinterface

interface d64r_rsp_if;
  logic            valid;
  logic            ready;
  d64r_pkg::byte_t data_byte;
  logic            file_end;
  logic            bad_link;

  modport source(output valid, data_byte, file_end, bad_link, input ready);
  modport sink(input valid, data_byte, file_end, bad_link, output ready);
endinterface

`default_nettype wire

/* rtl/d64r_mem.sv */
// Single-port disk image memory, one byte wide, registered read data.
// Depends on d64r_pkg.
`default_nettype none

module d64r_mem (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire d64r_pkg::addr_t addr,
  input  wire d64r_pkg::byte_t wdata,
  output d64r_pkg::byte_t      rdata
);
  import d64r_pkg::*;

  byte_t mem [0:IMAGE_BYTES-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/d64r_locate.sv */
// Shared locate unit: track/sector to sector index with range check.
// Depends on d64r_pkg.
`default_nettype none

module d64r_locate (
  input  wire d64r_pkg::byte_t track,
  input  wire d64r_pkg::byte_t sector,
  output d64r_pkg::loc_t       loc
);
  import d64r_pkg::*;

  logic track_ok;
  idx_t idx;

  assign track_ok = (track >= 8'd1) && (track <= 8'(NUM_TRACKS));
  assign idx      = track_base(track[5:0]) + {2'd0, sector};

  assign loc.ok  = track_ok && (idx < idx_t'(IMAGE_SECTORS));
  assign loc.idx = idx;

endmodule

`default_nettype wire

/* rtl/d64_sector_chain_file_reader_core.sv */
// Top level of the sector chain file reader: sequencer, state registers,
// result register. Depends on d64r_pkg, d64r_if, d64r_mem, d64r_locate.
//
//  channel | dir | payload                                          | handshake
//  req     | in  | op, image_address, image_byte, start_track/sector | valid/ready
//  rsp     | out | data_byte, file_end, bad_link                     | valid/ready
//
// Write, open and unused items are taken while idle. A read holds the input
// through the sequencer steps: prepare, locate, read data and link bytes,
// result. A bad location skips the reads; the sector link may be followed
// first, and a byte that ends a sector has the linked sector's links fetched.
// Reset is synchronous and clears the chain state; the image is not cleared.
// A new item is taken while a finished result still waits on rsp; a read then
// holds in its final step until the result register is free.
`default_nettype none

module d64_sector_chain_file_reader_core (
  input  wire logic   clk,
  input  wire logic   rst,
  d64r_req_if.sink    req,
  d64r_rsp_if.source  rsp
);
  import d64r_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_FL0  = 4'd2;
  localparam logic [3:0] S_FL1  = 4'd3;
  localparam logic [3:0] S_LOC  = 4'd4;
  localparam logic [3:0] S_RD0  = 4'd5;
  localparam logic [3:0] S_RD1  = 4'd6;
  localparam logic [3:0] S_RD2  = 4'd7;
  localparam logic [3:0] S_NX   = 4'd8;
  localparam logic [3:0] S_NX0  = 4'd9;
  localparam logic [3:0] S_NX1  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]       state;
  byte_t            cur_track, cur_sector;
  byte_t            chain_start_track, chain_start_sector;
  logic [POS_W-1:0] byte_pos;
  byte_t            link_t, link_s;
  idx_t             loc_idx;
  logic             link_zero;
  byte_t            res_data;
  logic             res_last, res_bad;

  logic  out_valid;
  byte_t out_data;
  logic  out_last, out_bad;

  logic  accept;
  logic  mem_we;
  addr_t mem_addr;
  byte_t mem_rdata;
  byte_t loc_track, loc_sector;
  loc_t  loc;
  byte_t count;

  assign req.ready     = !rst && (state == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.data_byte = out_data;
  assign rsp.file_end  = out_last;
  assign rsp.bad_link  = out_bad;

  assign mem_we = accept && (req.op == OP_WRITE) &&
                  (req.image_address < addr_t'(IMAGE_BYTES));

  // the locate unit serves the current sector, and the linked one at sector end
  assign loc_track  = (state == S_NX) ? link_t : cur_track;
  assign loc_sector = (state == S_NX) ? link_s : cur_sector;

  // data bytes read in this sector before the increment
  assign count = byte_pos[7:0] - 8'd1;

  always_comb begin
    unique case (state)
      S_IDLE:  mem_addr = req.image_address;
      S_PREP:  mem_addr = {loc.idx, 8'd0};
      S_FL0:   mem_addr = {loc_idx, LINK_SECTOR_OFS};
      S_LOC:   mem_addr = {loc.idx, byte_pos[7:0]};
      S_RD0:   mem_addr = {loc_idx, 8'd0};
      S_RD1:   mem_addr = {loc_idx, LINK_SECTOR_OFS};
      S_NX:    mem_addr = {loc.idx, 8'd0};
      S_NX0:   mem_addr = {loc_idx, LINK_SECTOR_OFS};
      default: mem_addr = '0;
    endcase
  end

  d64r_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req.image_byte),
    .rdata (mem_rdata)
  );

  d64r_locate u_locate (
    .track  (loc_track),
    .sector (loc_sector),
    .loc    (loc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      cur_track          <= '0;
      cur_sector         <= '0;
      byte_pos           <= '0;
      chain_start_track  <= '0;
      chain_start_sector <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req.op == OP_OPEN) begin
            chain_start_track  <= req.start_track;
            chain_start_sector <= req.start_sector;
            byte_pos           <= '0;
          end else if (accept && req.op == OP_READ) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (byte_pos == '0) begin
            cur_track  <= chain_start_track;
            cur_sector <= chain_start_sector;
            byte_pos   <= POS_W'(2);
            state      <= S_LOC;
          end else if (byte_pos[POS_W-1]) begin
            if (loc.ok) begin
              loc_idx <= loc.idx;
              state   <= S_FL0;
            end else begin
              byte_pos <= POS_W'(2);
              state    <= S_LOC;
            end
          end else begin
            state <= S_LOC;
          end
        end
        S_FL0: begin
          link_t <= mem_rdata;
          state  <= S_FL1;
        end
        S_FL1: begin
          cur_track  <= link_t;
          cur_sector <= mem_rdata;
          byte_pos   <= POS_W'(2);
          state      <= S_LOC;
        end
        S_LOC: begin
          if (loc.ok) begin
            loc_idx <= loc.idx;
            state   <= S_RD0;
          end else begin
            res_data <= '0;
            res_last <= 1'b0;
            res_bad  <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_RD0: begin
          res_data <= mem_rdata;
          res_bad  <= 1'b0;
          state    <= S_RD1;
        end
        S_RD1: begin
          link_t <= mem_rdata;
          state  <= S_RD2;
        end
        S_RD2: begin
          link_s   <= mem_rdata;
          byte_pos <= byte_pos + POS_W'(1);
          if (link_t == '0) begin
            res_last <= (count >= mem_rdata);
            state    <= S_OUT;
          end else if (count == 8'(DATA_PER_SECTOR)) begin
            state <= S_NX;
          end else begin
            res_last <= 1'b0;
            state    <= S_OUT;
          end
        end
        S_NX: begin
          if (loc.ok) begin
            loc_idx <= loc.idx;
            state   <= S_NX0;
          end else begin
            res_last <= 1'b0;
            state    <= S_OUT;
          end
        end
        S_NX0: begin
          link_zero <= (mem_rdata == '0);
          state     <= S_NX1;
        end
        S_NX1: begin
          res_last <= link_zero && (mem_rdata == '0);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload, loaded with out_valid
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || rsp.ready)) begin
      out_data <= res_data;
      out_last <= res_last;
      out_bad  <= res_bad;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= POS_W'(SECTOR_BYTES))
    else $error("byte position beyond sector end");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bad_link |-> !rsp.file_end && rsp.data_byte == '0)
    else $error("bad link result carries data or end flag");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.op == OP_READ |=> !req.ready)
    else $error("ready held during a read");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_OUT)
    else $error("result raised outside final step");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_IDLE && req.op == OP_WRITE)
    else $error("image write outside an accepted write item");
`endif

endmodule

`default_nettype wire
